// ----- hw/rtl/zwe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zwe_pkg
// Shared constants and types of the Zernike wavefront evaluator.
// ----------------------------------------------------------------------------
package zwe_pkg;

    localparam int COEF_WIDTH_DEF = 24;
    localparam int TERM_COUNT     = 12;
    localparam int FIRST_TERM     = 3;
    localparam int IDX_W          = 4;
    localparam int SLOT_W         = $clog2(TERM_COUNT);
    localparam int POS_W          = 16;
    localparam int OUT_W          = 40;
    localparam int QUEUE_DEPTH    = 4;

    // Q.28 intermediate powers and polynomial widths
    localparam int Q28_W  = 34;
    localparam int POLY_W = 40;
    localparam int POLY_SPLIT = 20;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    typedef struct packed {
        logic                    is_load;
        logic [SLOT_W-1:0]       slot;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
    } zwe_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } zwe_qstat_t;

endpackage

// ----- hw/rtl/zwe_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zwe_if
// Valid/ready channels of the evaluator: point/coefficient input, result.
// ----------------------------------------------------------------------------
interface zwe_in_if
    import zwe_pkg::*;
#(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [IDX_W-1:0]             coef_index;
    logic signed [COEF_WIDTH-1:0] coef_value;
    logic signed [POS_W-1:0]      x_pos;
    logic signed [POS_W-1:0]      y_pos;

    modport source (output valid, mode, coef_index, coef_value, x_pos, y_pos,
                    input ready);
    modport sink (input valid, mode, coef_index, coef_value, x_pos, y_pos,
                  output ready);
endinterface

interface zwe_out_if
    import zwe_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] wavefront_value;
    logic                    saturated;

    modport source (output valid, wavefront_value, saturated, input ready);
    modport sink (input valid, wavefront_value, saturated, output ready);
endinterface

// ----- hw/rtl/zernike_wavefront_evaluator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zernike_wavefront_evaluator
// Wavefront height from Zernike terms 3 to 14 at a Q1.14 pupil point.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock. A load writes one Q3.20
// coefficient into the twelve-entry table (cleared by reset) and returns
// nothing; loads of terms outside 3 to 14 are dropped. An evaluate returns
// one Q19.20 weighted sum, rounded half up and clipped with the saturated
// flag set. Results pass a four-entry queue and then a pipeline of seven
// register stages, and only output backpressure slows the rate below one
// per cycle. Results come out in input order, and a load affects every
// evaluate that follows it.
module zernike_wavefront_evaluator
    import zwe_pkg::*;
#(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    zwe_in_if.sink    req,
    zwe_out_if.source rsp
);

    localparam int QDW = $bits(zwe_cmd_t) + COEF_WIDTH;

    logic                  push;
    logic                  pop;
    zwe_cmd_t              f_cmd;
    logic [COEF_WIDTH-1:0] f_coef;
    zwe_cmd_t              q_cmd;
    logic [COEF_WIDTH-1:0] q_coef;
    zwe_qstat_t            q_stat;

    zwe_front #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_front (
        .req     (req),
        .q_ready (!q_stat.full),
        .push    (push),
        .cmd     (f_cmd),
        .coef    (f_coef)
    );

    zwe_queue #(
        .DW    (QDW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({f_cmd, f_coef}),
        .pop       (pop),
        .pop_data  ({q_cmd, q_coef}),
        .stat      (q_stat)
    );

    zwe_back #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (!q_stat.empty),
        .cmd     (q_cmd),
        .coef    (q_coef),
        .pop     (pop),
        .rsp     (rsp)
    );

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    a_sat_clipped: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.saturated) |->
            (rsp.wavefront_value == {1'b0, {(OUT_W-1){1'b1}}} ||
             rsp.wavefront_value == {1'b1, {(OUT_W-1){1'b0}}}))
        else $error("saturated result not at range limit");
`endif

endmodule

// ----- hw/rtl/zwe_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zwe_front
// Accepts input transactions, drops loads of unused terms, maps term to slot.
// ----------------------------------------------------------------------------
module zwe_front
    import zwe_pkg::*;
#(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF
)
(
    zwe_in_if.sink                 req,
    input  logic                   q_ready,
    output logic                   push,
    output zwe_cmd_t               cmd,
    output logic [COEF_WIDTH-1:0]  coef
);

    logic in_range;
    logic keep;

    assign in_range = (req.coef_index >= IDX_W'(FIRST_TERM)) &&
                      (req.coef_index <  IDX_W'(FIRST_TERM + TERM_COUNT));
    assign keep     = (req.mode == MODE_EVAL) || in_range;

    assign req.ready = q_ready;
    assign push      = req.valid && q_ready && keep;

    always_comb
    begin
        cmd.is_load = (req.mode == MODE_LOAD);
        cmd.slot    = SLOT_W'(req.coef_index - IDX_W'(FIRST_TERM));
        cmd.x       = req.x_pos;
        cmd.y       = req.y_pos;
    end

    assign coef = req.coef_value;

endmodule

// ----- hw/rtl/zwe_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zwe_queue
// Short FIFO between the front and the evaluation pipeline.
// ----------------------------------------------------------------------------
module zwe_queue
    import zwe_pkg::*;
#(
    parameter int DW    = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] push_data,
    input  logic          pop,
    output logic [DW-1:0] pop_data,
    output zwe_qstat_t    stat
);

    localparam int AW = $clog2(DEPTH);

    logic [DW-1:0] mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW:0]   cnt_reg;
    logic          do_push;
    logic          do_pop;

    assign stat.full  = (cnt_reg == (AW+1)'(DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- hw/rtl/zwe_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zwe_back
// Evaluation pipeline: powers, polynomials, coefficient table, weighted sum.
// ----------------------------------------------------------------------------
module zwe_back
    import zwe_pkg::*;
#(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  zwe_cmd_t              cmd,
    input  logic [COEF_WIDTH-1:0] coef,
    output logic                  pop,
    zwe_out_if.source             rsp
);

    localparam int CW   = COEF_WIDTH;
    localparam int HW   = POLY_W - POLY_SPLIT;
    localparam int LW   = POLY_SPLIT + 1;
    localparam int SW   = POLY_W + CW + 4;
    localparam int RW   = SW - 28;
    localparam int EW   = (RW > OUT_W) ? RW : OUT_W;
    localparam logic signed [EW-1:0] MAXV = (EW'(1) <<< (OUT_W-1)) - EW'(1);
    localparam logic signed [EW-1:0] MINV = -MAXV - EW'(1);
    localparam logic signed [SW-1:0] HALF = SW'(1) <<< 27;

    logic adv;
    logic a_v_reg, b_v_reg, c_v_reg, d_v_reg, e_v_reg, f_v_reg, g_v_reg;
    logic c_load_reg;

    assign adv = !g_v_reg || rsp.ready;
    assign pop = q_valid && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
            g_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_v_reg <= q_valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg && !c_load_reg;   // loads end at the table
            e_v_reg <= d_v_reg;
            f_v_reg <= e_v_reg;
            g_v_reg <= f_v_reg;
        end
    end

    // stage A: squares and the xy product
    logic                    a_load_reg;
    logic [SLOT_W-1:0]       a_slot_reg;
    logic signed [CW-1:0]    a_coef_reg;
    logic signed [POS_W-1:0] a_x_reg, a_y_reg;
    logic signed [31:0]      a_x2_reg, a_y2_reg, a_xy_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_load_reg <= cmd.is_load;
            a_slot_reg <= cmd.slot;
            a_coef_reg <= coef;
            a_x_reg    <= cmd.x;
            a_y_reg    <= cmd.y;
            a_x2_reg   <= cmd.x * cmd.x;
            a_y2_reg   <= cmd.y * cmd.y;
            a_xy_reg   <= cmd.x * cmd.y;
        end
    end

    // stage B: third and fourth order powers, floor to Q.28
    logic signed [47:0] p_x3, p_y3, p_x2y, p_xy2;
    logic signed [63:0] p_x4, p_y4, p_x2y2, p_x3y, p_xy3;

    assign p_x3   = a_x2_reg * a_x_reg;
    assign p_y3   = a_y2_reg * a_y_reg;
    assign p_x2y  = a_x2_reg * a_y_reg;
    assign p_xy2  = a_y2_reg * a_x_reg;
    assign p_x4   = a_x2_reg * a_x2_reg;
    assign p_y4   = a_y2_reg * a_y2_reg;
    assign p_x2y2 = a_x2_reg * a_y2_reg;
    assign p_x3y  = a_x2_reg * a_xy_reg;
    assign p_xy3  = a_xy_reg * a_y2_reg;

    logic                    b_load_reg;
    logic [SLOT_W-1:0]       b_slot_reg;
    logic signed [CW-1:0]    b_coef_reg;
    logic signed [POS_W-1:0] b_x_reg, b_y_reg;
    logic signed [Q28_W-1:0] b_x2_reg, b_y2_reg, b_xy_reg;
    logic signed [Q28_W-1:0] b_x3_reg, b_y3_reg, b_x2y_reg, b_xy2_reg;
    logic signed [Q28_W-1:0] b_x4_reg, b_y4_reg, b_x2y2_reg, b_x3y_reg, b_xy3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_load_reg <= a_load_reg;
            b_slot_reg <= a_slot_reg;
            b_coef_reg <= a_coef_reg;
            b_x_reg    <= a_x_reg;
            b_y_reg    <= a_y_reg;
            b_x2_reg   <= Q28_W'(a_x2_reg);
            b_y2_reg   <= Q28_W'(a_y2_reg);
            b_xy_reg   <= Q28_W'(a_xy_reg);
            b_x3_reg   <= Q28_W'(p_x3 >>> 14);
            b_y3_reg   <= Q28_W'(p_y3 >>> 14);
            b_x2y_reg  <= Q28_W'(p_x2y >>> 14);
            b_xy2_reg  <= Q28_W'(p_xy2 >>> 14);
            b_x4_reg   <= Q28_W'(p_x4 >>> 28);
            b_y4_reg   <= Q28_W'(p_y4 >>> 28);
            b_x2y2_reg <= Q28_W'(p_x2y2 >>> 28);
            b_x3y_reg  <= Q28_W'(p_x3y >>> 28);
            b_xy3_reg  <= Q28_W'(p_xy3 >>> 28);
        end
    end

    // stage C: the twelve polynomials, terms 3 to 14
    logic signed [POLY_W-1:0] poly [TERM_COUNT];

    always_comb
    begin
        logic signed [POLY_W-1:0] one, xq, yq, x2, y2, xy, x3, y3, x2y, xy2;
        logic signed [POLY_W-1:0] x4, y4, x2y2, x3y, xy3;
        one  = POLY_W'(1) <<< 28;
        xq   = POLY_W'(b_x_reg) <<< 14;
        yq   = POLY_W'(b_y_reg) <<< 14;
        x2   = POLY_W'(b_x2_reg);
        y2   = POLY_W'(b_y2_reg);
        xy   = POLY_W'(b_xy_reg);
        x3   = POLY_W'(b_x3_reg);
        y3   = POLY_W'(b_y3_reg);
        x2y  = POLY_W'(b_x2y_reg);
        xy2  = POLY_W'(b_xy2_reg);
        x4   = POLY_W'(b_x4_reg);
        y4   = POLY_W'(b_y4_reg);
        x2y2 = POLY_W'(b_x2y2_reg);
        x3y  = POLY_W'(b_x3y_reg);
        xy3  = POLY_W'(b_xy3_reg);
        poly[0]  = 2 * xy;
        poly[1]  = -one + 2 * x2 + 2 * y2;
        poly[2]  = y2 - x2;
        poly[3]  = -x3 + 3 * xy2;
        poly[4]  = -2 * xq + 3 * x3 + 3 * xy2;
        poly[5]  = -2 * yq + 3 * x2y + 3 * y3;
        poly[6]  = y3 - 3 * x2y;
        poly[7]  = -4 * x3y + 4 * xy3;
        poly[8]  = -6 * xy + 8 * x3y + 8 * xy3;
        poly[9]  = one - 6 * x2 - 6 * y2 + 6 * x4 + 6 * y4 + 12 * x2y2;
        poly[10] = 3 * x2 - 3 * y2 - 4 * x4 + 4 * y4;
        poly[11] = x4 - 6 * x2y2 + y4;
    end

    logic [SLOT_W-1:0]        c_slot_reg;
    logic signed [CW-1:0]     c_coef_reg;
    logic signed [POLY_W-1:0] c_poly_reg [TERM_COUNT];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_load_reg <= b_load_reg;
            c_slot_reg <= b_slot_reg;
            c_coef_reg <= b_coef_reg;
            for (int k = 0; k < TERM_COUNT; k++)
                c_poly_reg[k] <= poly[k];
        end
    end

    // stage D: coefficient table, written and read here to keep item order
    logic signed [CW-1:0] tab_reg [TERM_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TERM_COUNT; k++)
                tab_reg[k] <= '0;
        end
        else if (adv && c_v_reg && c_load_reg)
        begin
            tab_reg[c_slot_reg] <= c_coef_reg;
        end
    end

    logic signed [HW+CW-1:0] d_hi_reg [TERM_COUNT];
    logic signed [LW+CW-1:0] d_lo_reg [TERM_COUNT];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < TERM_COUNT; k++)
            begin
                d_hi_reg[k] <= $signed(c_poly_reg[k][POLY_W-1:POLY_SPLIT]) * tab_reg[k];
                d_lo_reg[k] <= $signed({1'b0, c_poly_reg[k][POLY_SPLIT-1:0]}) * tab_reg[k];
            end
        end
    end

    // stage E: rejoin split products, add in pairs
    logic signed [SW-1:0] e_pair_reg [TERM_COUNT/2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < TERM_COUNT/2; j++)
                e_pair_reg[j] <= (SW'(d_hi_reg[2*j]) <<< POLY_SPLIT) + SW'(d_lo_reg[2*j])
                               + (SW'(d_hi_reg[2*j+1]) <<< POLY_SPLIT)
                               + SW'(d_lo_reg[2*j+1]);
        end
    end

    // stage F: add in threes
    logic signed [SW-1:0] f_sum_reg [2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 2; i++)
                f_sum_reg[i] <= e_pair_reg[3*i] + e_pair_reg[3*i+1] + e_pair_reg[3*i+2];
        end
    end

    // stage G: final add, round half up to Q.20, clip
    logic signed [SW-1:0]    total;
    logic signed [RW-1:0]    rounded;
    logic signed [EW-1:0]    wide;
    logic signed [OUT_W-1:0] val_next;
    logic                    sat_next;

    assign total   = f_sum_reg[0] + f_sum_reg[1];
    assign rounded = RW'((total + HALF) >>> 28);
    assign wide    = EW'(rounded);

    always_comb
    begin
        if (wide > MAXV)
        begin
            val_next = OUT_W'(MAXV);
            sat_next = 1'b1;
        end
        else if (wide < MINV)
        begin
            val_next = OUT_W'(MINV);
            sat_next = 1'b1;
        end
        else
        begin
            val_next = OUT_W'(wide);
            sat_next = 1'b0;
        end
    end

    logic signed [OUT_W-1:0] g_val_reg;
    logic                    g_sat_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g_val_reg <= val_next;
            g_sat_reg <= sat_next;
        end
    end

    assign rsp.valid           = g_v_reg;
    assign rsp.wavefront_value = g_val_reg;
    assign rsp.saturated       = g_sat_reg;

endmodule

// ----- verif/zwe_wavefront_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zwe_wavefront_checker
// Watches both channels of the evaluator, keeps its own coefficient table,
// predicts each wavefront sum and compares it with the result stream.
// ----------------------------------------------------------------------------
module zwe_wavefront_checker
    import zwe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    zwe_in_if    req,
    zwe_out_if   rsp,
    output int   fail_count,
    output int   pending
);

    typedef struct {
        logic signed [OUT_W-1:0] value;
        logic                    sat;
    } wavefront_t;

    longint     coef_tab [TERM_COUNT];
    wavefront_t wavefront_q[$];

    function automatic wavefront_t wavefront_sum(logic signed [POS_W-1:0] xp,
                                                 logic signed [POS_W-1:0] yp);
        longint x, y, x2, y2, xy, x3, y3, x2y, xy2, x4, y4, x2y2, x3y, xy3;
        longint one, xq, yq;
        longint poly [TERM_COUNT];
        logic signed [127:0] acc, p, c, res, half, maxv, minv;
        wavefront_t r;
        x = xp;
        y = yp;
        one = 64'sd1 <<< 28;
        xq = x * 16384;
        yq = y * 16384;
        x2 = x * x;
        y2 = y * y;
        xy = x * y;
        x3 = (x2 * x) >>> 14;
        y3 = (y2 * y) >>> 14;
        x2y = (x2 * y) >>> 14;
        xy2 = (y2 * x) >>> 14;
        x4 = (x2 * x2) >>> 28;
        y4 = (y2 * y2) >>> 28;
        x2y2 = (x2 * y2) >>> 28;
        x3y = (x2 * xy) >>> 28;
        xy3 = (xy * y2) >>> 28;
        poly[0]  = 2 * xy;
        poly[1]  = -one + 2 * x2 + 2 * y2;
        poly[2]  = y2 - x2;
        poly[3]  = -x3 + 3 * xy2;
        poly[4]  = -2 * xq + 3 * x3 + 3 * xy2;
        poly[5]  = -2 * yq + 3 * x2y + 3 * y3;
        poly[6]  = y3 - 3 * x2y;
        poly[7]  = -4 * x3y + 4 * xy3;
        poly[8]  = -6 * xy + 8 * x3y + 8 * xy3;
        poly[9]  = one - 6 * x2 - 6 * y2 + 6 * x4 + 6 * y4 + 12 * x2y2;
        poly[10] = 3 * x2 - 3 * y2 - 4 * x4 + 4 * y4;
        poly[11] = x4 - 6 * x2y2 + y4;
        acc = 0;
        for (int k = 0; k < TERM_COUNT; k++)
        begin
            p = poly[k];
            c = coef_tab[k];
            acc = acc + p * c;
        end
        // Q.48 down to Q.20, round half up
        half = 128'sd32768;
        res = ((acc >>> 12) + half) >>> 16;
        maxv = (128'sd1 <<< (OUT_W - 1)) - 128'sd1;
        minv = -maxv - 128'sd1;
        r.sat = 1'b0;
        if (res > maxv)
        begin
            res = maxv;
            r.sat = 1'b1;
        end
        else if (res < minv)
        begin
            res = minv;
            r.sat = 1'b1;
        end
        r.value = res[OUT_W-1:0];
        return r;
    endfunction

    assign pending = wavefront_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        wavefront_t exp_r;
        int idx;
        if (!rst_n)
        begin
            for (int k = 0; k < TERM_COUNT; k++)
                coef_tab[k] = 0;
            wavefront_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                if (req.mode == MODE_LOAD)
                begin
                    idx = req.coef_index;
                    if (idx >= FIRST_TERM && idx < FIRST_TERM + TERM_COUNT)
                        coef_tab[idx - FIRST_TERM] = longint'(req.coef_value);
                end
                else
                    wavefront_q.push_back(wavefront_sum(req.x_pos, req.y_pos));
            end
            if (rsp.valid && rsp.ready)
            begin
                if (wavefront_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result value=%0d sat=%0b",
                                 rsp.wavefront_value, rsp.saturated);
                end
                else
                begin
                    exp_r = wavefront_q.pop_front();
                    if (rsp.wavefront_value !== exp_r.value || rsp.saturated !== exp_r.sat)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected value=%0d sat=%0b, got value=%0d sat=%0b",
                                     exp_r.value, exp_r.sat, rsp.wavefront_value,
                                     rsp.saturated);
                    end
                end
            end
        end
    end

endmodule

// ----- verif/zernike_wavefront_evaluator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zernike_wavefront_evaluator_tb
// Loads coefficient tables and evaluates pupil points, directed then random,
// with random gaps on the input and random stalls on the result channel.
// ----------------------------------------------------------------------------
module zernike_wavefront_evaluator_tb;
    import zwe_pkg::*;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycle_cnt;
    int   stall_left;

    zwe_in_if  req ();
    zwe_out_if rsp ();

    zernike_wavefront_evaluator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    zwe_wavefront_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        clk = 1'b0;
        req.valid = 1'b0;
        req.mode = MODE_LOAD;
        req.coef_index = '0;
        req.coef_value = '0;
        req.x_pos = '0;
        req.y_pos = '0;
        rsp.ready = 1'b0;
        stall_left = 0;
        cycle_cnt = 0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Random stalls on the result side, with quiet stretches in between
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= 1'b1;
                if ($urandom_range(0, 99) < 20)
                    stall_left <= gap_len();
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 400000)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_txn(logic m, logic [IDX_W-1:0] idx, logic [23:0] cv,
                            logic [POS_W-1:0] xp, logic [POS_W-1:0] yp);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            req.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.mode <= m;
        req.coef_index <= idx;
        req.coef_value <= cv;
        req.x_pos <= xp;
        req.y_pos <= yp;
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    task automatic load_coef(int idx, logic [23:0] cv);
        send_txn(MODE_LOAD, idx[IDX_W-1:0], cv, POS_W'($urandom()), POS_W'($urandom()));
    endtask

    task automatic eval_point(logic [POS_W-1:0] xp, logic [POS_W-1:0] yp);
        send_txn(MODE_EVAL, IDX_W'($urandom()), 24'($urandom()), xp, yp);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    function automatic logic [POS_W-1:0] rand_pos();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'h8000;
        if (r == 1)
            return 16'h7fff;
        if (r == 2)
            return 16'h0000;
        return POS_W'($urandom());
    endfunction

    initial
    begin
        int items;
        int r;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: cleared table, extreme coefficients, dropped indexes
        eval_point(16'h7fff, 16'h8000);
        for (int k = FIRST_TERM; k < FIRST_TERM + TERM_COUNT; k++)
            load_coef(k, 24'h7fffff);
        eval_point(16'h8000, 16'h8000);
        eval_point(16'h7fff, 16'h7fff);
        eval_point(16'h0000, 16'h0000);
        load_coef(0, 24'h800000);
        load_coef(1, 24'h800000);
        load_coef(2, 24'h800000);
        load_coef(15, 24'h800000);
        eval_point(16'h4000, 16'hc000);
        for (int k = FIRST_TERM; k < FIRST_TERM + TERM_COUNT; k++)
            load_coef(k, (k % 2) ? 24'h800000 : 24'h7fffff);
        eval_point(16'h8000, 16'h7fff);
        eval_point(16'h0001, 16'hffff);
        drain();

        items = 0;
        while (items < 400)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                // fresh full table
                for (int k = FIRST_TERM; k < FIRST_TERM + TERM_COUNT; k++)
                    load_coef(k, 24'($urandom()));
                items += TERM_COUNT;
            end
            else if (r < 20)
            begin
                load_coef($urandom_range(0, 15), 24'($urandom()));
                items++;
            end
            else
            begin
                eval_point(rand_pos(), rand_pos());
                items++;
            end
            // hold off until every outstanding result is back
            if (items % 150 == 0)
                drain();
        end
        drain();

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/zwe_pkg.sv
hw/rtl/zwe_if.sv
hw/rtl/zwe_front.sv
hw/rtl/zwe_queue.sv
hw/rtl/zwe_back.sv
hw/rtl/zernike_wavefront_evaluator.sv
verif/zwe_wavefront_checker.sv
verif/zernike_wavefront_evaluator_tb.sv
